// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: op codes, status codes, queue entry type.
// No dependencies.
`default_nettype none
package rau_pkg;
  typedef enum logic [3:0] {
    FN_NORM = 4'd0, FN_ADD = 4'd1, FN_SUB = 4'd2, FN_MUL = 4'd3, FN_DIV = 4'd4,
    FN_LT = 4'd5, FN_GT = 4'd6, FN_EQ = 4'd7, FN_NE = 4'd8
  } func_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] left_num;
    logic [31:0] left_den;
    logic [31:0] right_num;
    logic [30:0] right_den;
  } item_t;

  // Reducer phases.
  typedef enum logic [1:0] {RD_IDLE, RD_GCD, RD_DIV, RD_DONE} red_state_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    BK_IDLE, BK_RED_A, BK_WAIT_A, BK_RED_B, BK_WAIT_B,
    BK_MUL1, BK_MUL2, BK_COMBINE, BK_RED_R, BK_WAIT_R, BK_OUT
  } back_state_t;
endpackage
`default_nettype wire

// ===== src/rational_arith_unit_top.sv =====
// Rational arithmetic unit: a two-entry command queue feeds a sequencer that
// reduces the operands and, for add, sub, mul and div, the result with one shared
// gcd/divide unit, whose bit-serial divider sets the latency. One item is worked
// at a time; the queue takes up to two more. Result strobe lasts one cycle. Sync
// reset empties all.
`default_nettype none
module rational_arith_unit_top #(
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  func,
  input  wire logic [31:0] left_num,
  input  wire logic [31:0] left_den,
  input  wire logic [31:0] right_num,
  input  wire logic [30:0] right_den,
  output logic             strobe,
  output logic [31:0]      res_num,
  output logic [30:0]      res_den,
  output logic             cmp_true,
  output logic [1:0]       status
);
  rau_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;

  assign in_item = '{func: func, left_num: left_num, left_den: left_den,
                     right_num: right_num, right_den: right_den};

  rau_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .done(strobe), .res_num(res_num), .res_den(res_den),
    .cmp_true(cmp_true), .status(status)
  );
endmodule
`default_nettype wire

// ===== src/rau_front.sv =====
// Front part: takes commands and holds them in a two-entry queue.
// Depends on rau_pkg.
`default_nettype none
module rau_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire rau_pkg::item_t in_item,
  output logic                busy,
  output logic                q_valid,
  output rau_pkg::item_t      q_item,
  input  wire logic           q_pop
);
  rau_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule
`default_nettype wire

// ===== src/rau_reduce.sv =====
// Fraction reducer: Euclid gcd by iterated restoring-division remainder, then
// two restoring divisions by the gcd, then sign and range check.
// Depends on rau_pkg.
`default_nettype none
module rau_reduce #(
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [64:0] n_in,   // signed
  input  wire logic [64:0] d_in,   // signed
  output logic             done,
  output logic [31:0]      r_num,
  output logic [31:0]      r_den,
  output logic [1:0]       r_status
);
  localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

  rau_pkg::red_state_t state, state_next;
  logic [63:0] an, ad, ga, gb;
  logic [63:0] quo, rem, dvs;   // shared restoring divider
  logic [6:0]  cnt;
  logic        div_run;
  logic        phase;           // 0: divide to start, 1: divide started
  logic        which;           // quotient of num (0) or den (1)
  logic        neg;
  logic [63:0] qn;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dvs};

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::RD_IDLE: if (go) state_next = rau_pkg::RD_GCD;
      rau_pkg::RD_GCD:  if (!div_run && gb == 64'd0) state_next = rau_pkg::RD_DIV;
      rau_pkg::RD_DIV:  if (!div_run && which && phase) state_next = rau_pkg::RD_DONE;
      rau_pkg::RD_DONE: state_next = rau_pkg::RD_IDLE;
      default:          state_next = rau_pkg::RD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rau_pkg::RD_IDLE;
    else     state <= state_next;
  end

  assign done = (state == rau_pkg::RD_DONE);

  // Datapath: one quotient bit per cycle while a division runs
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
    end else begin
      case (state)
        rau_pkg::RD_IDLE: begin
          div_run <= 1'b0;
          if (go) begin
            neg   <= n_in[64] ^ d_in[64];
            an    <= n_in[64] ? 64'(-n_in) : n_in[63:0];
            ad    <= d_in[64] ? 64'(-d_in) : d_in[63:0];
            ga    <= n_in[64] ? 64'(-n_in) : n_in[63:0];
            gb    <= d_in[64] ? 64'(-d_in) : d_in[63:0];
            phase <= 1'b0;
            which <= 1'b0;
          end
        end
        rau_pkg::RD_GCD, rau_pkg::RD_DIV: begin
          if (div_run) begin
            if (!trial[64]) begin
              rem <= trial[63:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], quo[63]};
              quo <= {quo[62:0], 1'b0};
            end
            cnt <= cnt - 7'd1;
            if (cnt == 7'd1) div_run <= 1'b0;
          end else if (state == rau_pkg::RD_GCD) begin
            if (phase) begin
              ga <= gb;
              gb <= rem;
              phase <= 1'b0;
            end else if (gb != 64'd0) begin
              quo <= ga; rem <= 64'd0; dvs <= gb; cnt <= 7'd64;
              div_run <= 1'b1; phase <= 1'b1;
            end else begin
              phase <= 1'b0;
            end
          end else begin
            if (!phase) begin
              quo <= which ? ad : an; rem <= 64'd0; dvs <= ga; cnt <= 7'd64;
              div_run <= 1'b1; phase <= 1'b1;
            end else if (!which) begin
              qn <= quo; which <= 1'b1; phase <= 1'b0;
            end
          end
        end
        default: div_run <= 1'b0;
      endcase
    end
  end

  // Result formatting from final quotients
  always_comb begin
    r_num    = 32'd0;
    r_den    = 32'd1;
    r_status = rau_pkg::ST_OK;
    if (ad == 64'd0) begin
      r_status = rau_pkg::ST_ZERO_DEN;
    end else if (an != 64'd0) begin
      if (quo > LIM - 64'd1 || qn > (neg ? LIM : LIM - 64'd1)) begin
        r_status = rau_pkg::ST_OVERFLOW;
      end else begin
        r_num = neg ? 32'(-qn) : qn[31:0];
        r_den = quo[31:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/rau_back.sv =====
// Back part: sequences operand reduction, cross products, result reduction.
// Depends on rau_pkg and rau_reduce.
`default_nettype none
module rau_back #(
  parameter int WORD_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire rau_pkg::item_t q_item,
  output logic                q_pop,
  output logic                done,
  output logic [31:0]         res_num,
  output logic [30:0]         res_den,
  output logic                cmp_true,
  output logic [1:0]          status
);
  rau_pkg::back_state_t state, state_next;
  rau_pkg::item_t it;
  logic [31:0] an, ad, bn, bd;
  logic [63:0] x, y, z;
  logic [1:0]  st;
  logic        cmp;
  logic        red_go, red_done;
  logic [64:0] red_n, red_d;
  logic [31:0] rn, rd;
  logic [1:0]  rs;
  logic [31:0] ma, mb, mc, md;
  logic [63:0] p0, p1;

  rau_reduce #(.WORD_BITS(WORD_BITS)) u_red (
    .clk(clk), .rst(rst), .go(red_go), .n_in(red_n), .d_in(red_d),
    .done(red_done), .r_num(rn), .r_den(rd), .r_status(rs)
  );

  // Two signed 32x32 products per step
  assign p0 = 64'($signed(ma) * $signed(mb));
  assign p1 = 64'($signed(mc) * $signed(md));

  always_comb begin
    ma = an; mb = bd; mc = bn; md = ad;
    if (state == rau_pkg::BK_MUL2) begin
      ma = ad; mb = bd;
      if (it.func == rau_pkg::FN_MUL) begin
        mc = an; md = bn;
      end
    end
  end

  // Reducer operand select
  always_comb begin
    red_n = 65'd0;
    red_d = 65'd1;
    red_go = 1'b0;
    case (state)
      rau_pkg::BK_RED_A: begin
        red_n = {{33{it.left_num[31]}}, it.left_num};
        red_d = {{33{it.left_den[31]}}, it.left_den};
        red_go = 1'b1;
      end
      rau_pkg::BK_RED_B: begin
        red_n = {{33{it.right_num[31]}}, it.right_num};
        red_d = {34'd0, it.right_den};
        red_go = 1'b1;
      end
      rau_pkg::BK_RED_R: begin
        red_n = {z[63], z};
        red_d = (it.func == rau_pkg::FN_DIV) ? {y[63], y} : {x[63], x};
        red_go = 1'b1;
      end
      default: ;
    endcase
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      rau_pkg::BK_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        state_next = rau_pkg::BK_RED_A;
      end
      rau_pkg::BK_RED_A:  state_next = rau_pkg::BK_WAIT_A;
      rau_pkg::BK_WAIT_A: if (red_done) begin
        if (it.func == rau_pkg::FN_NORM || it.func > rau_pkg::FN_NE || rs != rau_pkg::ST_OK)
          state_next = rau_pkg::BK_OUT;
        else
          state_next = rau_pkg::BK_RED_B;
      end
      rau_pkg::BK_RED_B:  state_next = rau_pkg::BK_WAIT_B;
      rau_pkg::BK_WAIT_B: if (red_done) begin
        state_next = (rs != rau_pkg::ST_OK) ? rau_pkg::BK_OUT : rau_pkg::BK_MUL1;
      end
      rau_pkg::BK_MUL1:    state_next = rau_pkg::BK_MUL2;
      rau_pkg::BK_MUL2:    state_next = rau_pkg::BK_COMBINE;
      rau_pkg::BK_COMBINE: begin
        if (it.func >= rau_pkg::FN_LT) state_next = rau_pkg::BK_OUT;
        else state_next = rau_pkg::BK_RED_R;
      end
      rau_pkg::BK_RED_R:  state_next = rau_pkg::BK_WAIT_R;
      rau_pkg::BK_WAIT_R: if (red_done) state_next = rau_pkg::BK_OUT;
      rau_pkg::BK_OUT:    state_next = rau_pkg::BK_IDLE;
      default:            state_next = rau_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rau_pkg::BK_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::BK_IDLE: begin
        it <= q_item;
        st <= rau_pkg::ST_OK;
        cmp <= 1'b0;
        an <= 32'd0; ad <= 32'd1;
      end
      rau_pkg::BK_WAIT_A: if (red_done) begin
        st <= rs;
        if (it.func == rau_pkg::FN_NORM) begin
          an <= rn; ad <= rd;
        end else begin
          an <= rn; ad <= rd;
          if (it.func > rau_pkg::FN_NE) begin
            st <= rau_pkg::ST_OK; an <= 32'd0; ad <= 32'd1;
          end
        end
      end
      rau_pkg::BK_WAIT_B: if (red_done) begin
        st <= rs; bn <= rn; bd <= rd;
      end
      rau_pkg::BK_MUL1: begin
        x <= p0;   // an*bd
        y <= p1;   // bn*ad
      end
      rau_pkg::BK_MUL2: begin
        if (it.func == rau_pkg::FN_MUL) begin
          z <= p1; x <= p0;
        end else if (it.func == rau_pkg::FN_DIV) begin
          z <= x;
        end else if (it.func == rau_pkg::FN_ADD || it.func == rau_pkg::FN_SUB) begin
          z <= (it.func == rau_pkg::FN_ADD) ? x + y : x - y;
          x <= p0;
        end
      end
      rau_pkg::BK_COMBINE: begin
        an <= 32'd0; ad <= 32'd1;
        case (it.func)
          rau_pkg::FN_LT: cmp <= $signed(x) < $signed(y);
          rau_pkg::FN_GT: cmp <= $signed(x) > $signed(y);
          rau_pkg::FN_EQ: cmp <= (an == bn) && (ad == bd);
          rau_pkg::FN_NE: cmp <= !((an == bn) && (ad == bd));
          default: cmp <= 1'b0;
        endcase
      end
      rau_pkg::BK_WAIT_R: if (red_done) begin
        st <= rs; an <= rn; ad <= rd;
      end
      default: ;
    endcase
  end

  assign done     = (state == rau_pkg::BK_OUT);
  assign res_num  = (st != rau_pkg::ST_OK) ? 32'd0 : an;
  assign res_den  = (st != rau_pkg::ST_OK) ? 31'd1 : ad[30:0];
  assign cmp_true = (st != rau_pkg::ST_OK) ? 1'b0 : cmp;
  assign status   = st;
endmodule
`default_nettype wire

// ===== src/rau_checker.sv =====
// Port checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
`default_nettype none
module rau_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        strobe,
  input wire logic [30:0] res_den,
  input wire logic [31:0] res_num,
  input wire logic        cmp_true,
  input wire logic [1:0]  status
);
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("back-to-back strobe");
  a_status: assert property (@(posedge clk) disable iff (rst)
    strobe |-> status != 2'd3) else $error("bad status");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status != rau_pkg::ST_OK |-> res_num == 32'd0 && res_den == 31'd1 && !cmp_true)
    else $error("fault result not 0/1");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    strobe |-> res_den != 31'd0) else $error("zero denominator out");
endmodule

bind rational_arith_unit_top rau_checker u_chk (
  .clk(clk), .rst(rst), .strobe(strobe), .res_den(res_den), .res_num(res_num),
  .cmp_true(cmp_true), .status(status)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for rational_arith_unit_top: random and directed fraction commands,
// checked against an in-bench reduced-fraction predictor.
// Depends on rau_pkg and rational_arith_unit_top.
`timescale 1ns / 1ps
module tb;
  localparam int          WB        = 32;
  localparam int          N_RAND    = 1430;
  localparam longint      CYC_LIMIT = 100000000;
  localparam int          MAX_SHOWN = 10;

  // One command item; drain makes the driver wait until all results are back.
  typedef struct {
    logic [3:0]  fn;
    logic [31:0] ln;
    logic [31:0] ld;
    logic [31:0] rn;
    logic [30:0] rd;
    bit          drain;
  } cmd_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        cmp;
    logic [1:0]  st;
  } answer_t;

  typedef struct {
    longint     num;
    longint     den;
    logic [1:0] st;
  } frac_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  func = '0;
  logic [31:0] left_num = '0;
  logic [31:0] left_den = '0;
  logic [31:0] right_num = '0;
  logic [30:0] right_den = '0;
  logic        strobe;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        cmp_true;
  logic [1:0]  status;

  cmd_t    pending_cmds[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  longint  cycles = 0;
  bit      took = 0;
  bit      holding = 0;
  int      gap_left = 0;
  bit      stim_done = 0;

  rational_arith_unit_top #(.WORD_BITS(WB)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .left_num(left_num), .left_den(left_den), .right_num(right_num),
    .right_den(right_den), .strobe(strobe), .res_num(res_num),
    .res_den(res_den), .cmp_true(cmp_true), .status(status)
  );

  always #6 clk = ~clk;

  // Euclid on magnitudes
  function automatic longint unsigned gcd_u(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Reduce n/d, sign to numerator, range check at WB bits
  function automatic frac_t reduce_frac(longint n, longint d);
    frac_t r;
    longint unsigned an, ad, g, lim;
    bit neg;
    r.num = 0;
    r.den = 1;
    r.st = rau_pkg::ST_OK;
    if (d == 0) begin
      r.st = rau_pkg::ST_ZERO_DEN;
      return r;
    end
    if (n == 0) return r;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    g = gcd_u(an, ad);
    an = an / g;
    ad = ad / g;
    lim = 64'd1 << (WB - 1);
    if (ad > lim - 1 || an > (neg ? lim : lim - 1)) begin
      r.st = rau_pkg::ST_OVERFLOW;
      return r;
    end
    r.num = neg ? -longint'(an) : longint'(an);
    r.den = longint'(ad);
    return r;
  endfunction

  function automatic answer_t predict_fraction_op(logic [3:0] fn, logic [31:0] ln,
      logic [31:0] ld, logic [31:0] rn, logic [30:0] rd);
    frac_t a, b, r;
    answer_t ans;
    logic c;
    longint x, y;
    a = reduce_frac(longint'($signed(ln)), longint'($signed(ld)));
    b = reduce_frac(longint'($signed(rn)), longint'({33'd0, rd}));
    r.num = 0;
    r.den = 1;
    r.st = rau_pkg::ST_OK;
    c = 1'b0;
    if (fn == rau_pkg::FN_NORM) begin
      r = a;
    end else if (fn <= rau_pkg::FN_NE) begin
      if (a.st != rau_pkg::ST_OK) r.st = a.st;
      else if (b.st != rau_pkg::ST_OK) r.st = b.st;
      else begin
        x = a.num * b.den;
        y = b.num * a.den;
        case (fn)
          rau_pkg::FN_ADD: r = reduce_frac(x + y, a.den * b.den);
          rau_pkg::FN_SUB: r = reduce_frac(x - y, a.den * b.den);
          rau_pkg::FN_MUL: r = reduce_frac(a.num * b.num, a.den * b.den);
          rau_pkg::FN_DIV: r = reduce_frac(x, y);
          rau_pkg::FN_LT:  c = x < y;
          rau_pkg::FN_GT:  c = x > y;
          rau_pkg::FN_EQ:  c = (a.num == b.num) && (a.den == b.den);
          default: c = !((a.num == b.num) && (a.den == b.den));
        endcase
      end
    end
    if (r.st != rau_pkg::ST_OK) begin
      r.num = 0;
      r.den = 1;
      c = 1'b0;
    end
    ans.num = r.num[31:0];
    ans.den = r.den[30:0];
    ans.cmp = c;
    ans.st = r.st;
    return ans;
  endfunction

  // Mostly small magnitudes keep the gcd short; some full-width and extremes
  function automatic logic [31:0] rand_word();
    logic [31:0] pick[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff, 32'd0};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($signed($urandom_range(0, 120)) - 60);
      5, 6:          return $urandom;
      7:             return pick[$urandom_range(0, 4)];
      default:       return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 19))
      0:       return 31'd0;
      1, 2:    return 31'($urandom);
      3:       return 31'h7fff_ffff;
      4, 5:    return 31'($urandom_range(1, 100000));
      default: return 31'($urandom_range(1, 60));
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [3:0] fn, logic [31:0] ln, logic [31:0] ld,
      logic [31:0] rn, logic [30:0] rd, bit drain);
    cmd_t c;
    c.fn = fn;
    c.ln = ln;
    c.ld = ld;
    c.rn = rn;
    c.rd = rd;
    c.drain = drain;
    return c;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // Accept items and check results at the rising edge
  always @(posedge clk) begin
    answer_t e;
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
    if (!rst && strobe) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result num=%h den=%h cmp=%b st=%0d",
                   res_num, res_den, cmp_true, status);
      end else begin
        e = expected_answers.pop_front();
        if (res_num !== e.num || res_den !== e.den || cmp_true !== e.cmp ||
            status !== e.st) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: exp %h/%h cmp=%b st=%0d got %h/%h cmp=%b st=%0d",
                     e.num, e.den, e.cmp, e.st, res_num, res_den, cmp_true, status);
        end
      end
    end
    if (!rst && start && !busy) begin
      expected_answers.push_back(predict_fraction_op(func, left_num, left_den,
                                                     right_num, right_den));
      took = 1;
    end
  end

  // Drive items at the falling edge
  always @(negedge clk) begin
    cmd_t c;
    if (took) begin
      took = 0;
      holding = 0;
    end
    if (!rst && !holding) begin
      if (gap_left > 0) gap_left--;
      else if (pending_cmds.size() != 0 &&
               !(pending_cmds[0].drain && expected_answers.size() != 0)) begin
        c = pending_cmds.pop_front();
        func <= c.fn;
        left_num <= c.ln;
        left_den <= c.ld;
        right_num <= c.rn;
        right_den <= c.rd;
        holding = 1;
        gap_left = pick_gap();
      end
    end
    start <= holding;
  end

  // Fill the item queue, then wait for the drain and report
  initial begin
    logic [3:0]  fn;
    logic [31:0] ln, ld, rn, k;
    logic [30:0] rd;
    int stretch;
    // directed: extremes, each op, zero denominators, overflow, unused codes
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NORM, 32'h8000_0000, 32'hffff_ffff,
                                    0, 1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NORM, 32'h8000_0000, 32'd1, 0, 1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NORM, 32'd6, 32'hffff_fffc, 0, 1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NORM, 32'd0, 32'hffff_fff9, 0, 1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NORM, 32'd5, 32'd0, 0, 1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NORM, 32'd7, 32'h8000_0000, 0, 1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_ADD, 32'd1, 32'd2, 32'd1, 31'd3, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_ADD, 32'h7fff_ffff, 32'd1, 32'd1,
                                    31'd1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_SUB, 32'h8000_0000, 32'd1, 32'd1,
                                    31'd1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_SUB, 32'd3, 32'd4, 32'd3, 31'd4, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_MUL, 32'h7fff_ffff, 32'd1,
                                    32'h7fff_ffff, 31'd1, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_MUL, 32'd2, 32'h7fff_ffff, 32'd3,
                                    31'h7fff_ffff, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_DIV, 32'd1, 32'd2, 32'd0, 31'd5, 1));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_DIV, 32'hffff_fffd, 32'd4, 32'd9,
                                    31'd8, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_LT, 32'd1, 32'd3, 32'd1, 31'd2, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_GT, 32'd1, 32'd3, 32'd1, 31'd2, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_EQ, 32'd2, 32'd4, 32'd1, 31'd2, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_NE, 32'd2, 32'd4, 32'd1, 31'd2, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_ADD, 32'd1, 32'd0, 32'd1, 31'd0, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_LT, 32'h8000_0000, 32'hffff_ffff,
                                    32'd1, 31'd0, 0));
    pending_cmds.push_back(make_cmd(rau_pkg::FN_EQ, 32'd1, 32'd2, 32'd3, 31'd0, 0));
    pending_cmds.push_back(make_cmd(4'd9, 32'd1, 32'd2, 32'd3, 31'd4, 0));
    pending_cmds.push_back(make_cmd(4'd15, 32'hffff_ffff, 32'hffff_ffff,
                                    32'hffff_ffff, 31'h7fff_ffff, 1));
    // random items; compares often get an equal-valued right operand
    for (int i = 0; i < N_RAND; i++) begin
      fn = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      ln = rand_word();
      ld = (fn == rau_pkg::FN_NORM || $urandom_range(0, 14) == 0) ? rand_word()
                                                                  : {1'b0, rand_den()};
      rn = rand_word();
      rd = rand_den();
      if (fn >= rau_pkg::FN_LT && fn <= rau_pkg::FN_NE && $urandom_range(0, 2) == 0) begin
        k = 32'($urandom_range(1, 5));
        ld = 32'($urandom_range(1, 1000));
        ln = 32'($signed($urandom_range(0, 2000)) - 1000);
        rn = ln * k;
        rd = 31'(ld * k);
      end
      pending_cmds.push_back(make_cmd(fn, ln, ld, rn, rd, (i % 300) == 150));
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && !holding);
    stretch = 0;
    while (expected_answers.size() != 0 && stretch < 200000) begin
      @(posedge clk);
      stretch++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

// ===== rational_arith_unit_top.f =====
src/rau_pkg.sv
src/rau_front.sv
src/rau_reduce.sv
src/rau_back.sv
src/rational_arith_unit_top.sv
src/rau_checker.sv
tb/tb.sv
